// File: rtl/fpu_stack_execution_unit_macros.svh
// Assertion helpers shared by the execution unit modules.
`ifndef FPU_STACK_EXECUTION_UNIT_MACROS_SVH
`define FPU_STACK_EXECUTION_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FPSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define FPSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fpsu_pkg.sv
package fpsu_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int FVAL_W      = 43;
    localparam int DIV_STEPS   = 25;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [15:0] CTRL_DEFAULT  = 16'h037f;
    localparam logic [15:0] CTRL_EXC_MASK = 16'h003f;
    localparam logic [31:0] INF_BITS      = 32'h7f80_0000;
    localparam logic signed [16:0] EXP_BIAS = 17'sd127;
    localparam logic signed [16:0] EXP_MAX  = 17'sd255;

    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_FIN  = 2'd1,
        K_INF  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [15:0] exp;
        logic [23:0] sig;
    } t_fval;

    typedef enum logic [2:0] {
        R_INIT  = 3'd0,
        R_LOAD  = 3'd1,
        R_STORE = 3'd2,
        R_LDCW  = 3'd3,
        R_ADD   = 3'd4,
        R_SUB   = 3'd5,
        R_MUL   = 3'd6,
        R_DIV   = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        P_DONE = 2'd0,
        P_ADD  = 2'd1,
        P_MUL  = 2'd2,
        P_DIV  = 2'd3
    } t_path;

    typedef struct packed {
        logic accept;
        logic read;
        logic exec;
        logic add;
        logic norm;
        logic div;
        logic pack;
        logic fin;
    } t_cmd;

    typedef struct packed {
        t_path path;
        logic  add_zero;
        logic  norm_done;
        logic  div_last;
    } t_sts;

endpackage

// File: rtl/fpsu_ram.sv
module fpsu_ram #(
    parameter int WIDTH = fpsu_pkg::FVAL_W,
    parameter int DEPTH = fpsu_pkg::STACK_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write one word, read two words registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

// File: rtl/fpsu_ctrl.sv
module fpsu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_stall,
    input  fpsu_pkg::t_sts i_sts,
    output fpsu_pkg::t_cmd o_cmd,
    output logic           o_stall,
    output logic           o_valid
);

    `include "fpu_stack_execution_unit_macros.svh"

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_EXEC = 9'b000000100,
        S_ADD  = 9'b000001000,
        S_NORM = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_PACK = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // decode commands from state
    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && i_valid;
        o_cmd.read   = (r_state == S_READ);
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.add    = (r_state == S_ADD);
        o_cmd.norm   = (r_state == S_NORM);
        o_cmd.div    = (r_state == S_DIV);
        o_cmd.pack   = (r_state == S_PACK);
        o_cmd.fin    = (r_state == S_FIN);
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // advance through the instruction
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                unique case (i_sts.path)
                    fpsu_pkg::P_ADD: n_state = S_ADD;
                    fpsu_pkg::P_MUL: n_state = S_PACK;
                    fpsu_pkg::P_DIV: n_state = S_DIV;
                    default:         n_state = S_FIN;
                endcase
            end
            S_ADD:  n_state = i_sts.add_zero ? S_FIN : S_NORM;
            S_NORM: if (i_sts.norm_done) n_state = S_FIN;
            S_DIV:  if (i_sts.div_last) n_state = S_PACK;
            S_PACK: n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `FPSU_ASSERT_NEXT(a_accept_reads, o_cmd.accept, r_state == S_READ, "accept did not read")
    `FPSU_ASSERT_NEXT(a_out_holds, (r_state == S_OUT) && i_stall, r_state == S_OUT,
        "stalled word dropped")
    `FPSU_ASSERT_NEXT(a_div_runs, (r_state == S_DIV) && !i_sts.div_last, r_state == S_DIV,
        "divide left early")

endmodule

// File: rtl/fpsu_dp.sv
module fpsu_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fpsu_pkg::t_cmd i_cmd,
    output fpsu_pkg::t_sts o_sts,
    input  logic [2:0]     i_req_type,
    input  logic [31:0]    i_operand_bits,
    input  logic [2:0]     i_st_index,
    output logic           o_result_code,
    output logic [31:0]    o_store_bits,
    output logic [15:0]    o_status_out,
    output logic [15:0]    o_control_out,
    output logic [7:0]     o_tag_valid_bits,
    output logic           o_exception_pending
);

    `include "fpu_stack_execution_unit_macros.svh"

    localparam int PW = fpsu_pkg::PTR_W;
    localparam int SD = fpsu_pkg::STACK_DEPTH;

    // instruction
    fpsu_pkg::t_req r_req, n_req;
    logic [31:0]    r_word, n_word;
    logic [PW-1:0]  r_idx, n_idx;
    // architectural state
    logic [PW-1:0]  r_top, n_top;
    logic [SD-1:0]  r_occ, n_occ;
    logic           r_ie, n_ie, r_ze, n_ze, r_sf, n_sf, r_es, n_es;
    logic [5:0]     r_mask, n_mask;
    logic           r_pend, n_pend;
    // result
    logic           r_code, n_code;
    logic [31:0]    r_store, n_store;
    logic           r_wr, n_wr;
    logic [PW-1:0]  r_wslot, n_wslot;
    fpsu_pkg::t_fval r_res, n_res;
    // arithmetic working registers
    logic           r_neg, n_neg;
    logic [15:0]    r_exp, n_exp;
    logic [23:0]    r_asig, n_asig, r_bsig, n_bsig;
    logic           r_aneg, n_aneg, r_bneg, n_bneg;
    logic [5:0]     r_sha, n_sha, r_shb, n_shb;
    logic [32:0]    r_mag, n_mag;
    logic [47:0]    r_prod, n_prod;
    logic [23:0]    r_rem, n_rem, r_dvsr, n_dvsr;
    logic           r_feed, n_feed;
    logic [24:0]    r_q, n_q;
    logic [fpsu_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // stack memory
    logic [fpsu_pkg::FVAL_W-1:0] ram_rd0, ram_rd1;
    logic [PW-1:0]   src_slot, push_slot;
    fpsu_pkg::t_fval ra, rb, rbx;

    assign src_slot  = r_top + r_idx;
    assign push_slot = r_top - PW'(1);

    fpsu_ram #(
        .WIDTH (fpsu_pkg::FVAL_W),
        .DEPTH (SD)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (i_cmd.fin && r_wr),
        .i_waddr  (r_wslot),
        .i_wdata  (r_res),
        .i_re     (i_cmd.read),
        .i_raddr0 (r_top),
        .i_raddr1 (src_slot),
        .o_rdata0 (ram_rd0),
        .o_rdata1 (ram_rd1)
    );

    assign ra = fpsu_pkg::t_fval'(ram_rd0);
    assign rb = fpsu_pkg::t_fval'(ram_rd1);

    // flip the right operand for subtract
    always_comb begin
        rbx = rb;
        if (r_req == fpsu_pkg::R_SUB) rbx.neg = !rb.neg;
    end

    // resolve zero and infinity operands, pick the long path
    fpsu_pkg::t_path sp_path;
    fpsu_pkg::t_fval sp_res;
    logic            sp_fail, sp_ze, arith, occ_ok, both_fin;

    always_comb begin
        arith    = (r_req == fpsu_pkg::R_ADD) || (r_req == fpsu_pkg::R_SUB) ||
                   (r_req == fpsu_pkg::R_MUL) || (r_req == fpsu_pkg::R_DIV);
        occ_ok   = r_occ[r_top] && r_occ[src_slot];
        both_fin = (ra.kind == fpsu_pkg::K_FIN) && (rbx.kind == fpsu_pkg::K_FIN);
        sp_path  = fpsu_pkg::P_DONE;
        sp_fail  = 1'b0;
        sp_ze    = 1'b0;
        sp_res   = ra;
        if (arith && occ_ok) begin
            unique case (r_req)
                fpsu_pkg::R_ADD, fpsu_pkg::R_SUB: begin
                    if (ra.kind == fpsu_pkg::K_ZERO) sp_res = rbx;
                    else if (rbx.kind == fpsu_pkg::K_ZERO) sp_res = ra;
                    else if (both_fin) sp_path = fpsu_pkg::P_ADD;
                    else sp_fail = 1'b1;
                end
                fpsu_pkg::R_MUL: begin
                    if (ra.kind == fpsu_pkg::K_ZERO || rbx.kind == fpsu_pkg::K_ZERO) begin
                        sp_res = '{kind: fpsu_pkg::K_ZERO, neg: ra.neg ^ rbx.neg,
                                   exp: '0, sig: '0};
                    end else if (both_fin) sp_path = fpsu_pkg::P_MUL;
                    else sp_fail = 1'b1;
                end
                fpsu_pkg::R_DIV: begin
                    if (rbx.kind == fpsu_pkg::K_ZERO) begin
                        sp_ze  = 1'b1;
                        sp_res = '{kind: fpsu_pkg::K_INF, neg: ra.neg ^ rbx.neg,
                                   exp: '0, sig: '0};
                    end else if (ra.kind == fpsu_pkg::K_ZERO) begin
                        sp_res = '{kind: fpsu_pkg::K_ZERO, neg: ra.neg ^ rbx.neg,
                                   exp: '0, sig: '0};
                    end else if (both_fin && rbx.sig != 24'd0) sp_path = fpsu_pkg::P_DIV;
                    else sp_fail = 1'b1;
                end
                default: sp_fail = 1'b0;
            endcase
        end
    end

    // exponent alignment for add
    logic signed [16:0] ediff;
    logic [16:0]        ndiff;
    logic               a_lt_b;

    assign ediff  = $signed({ra.exp[15], ra.exp}) - $signed({rbx.exp[15], rbx.exp});
    assign ndiff  = 17'(-ediff);
    assign a_lt_b = ediff[16];

    // store encoding of ST0
    logic signed [16:0] enc_e;
    logic               enc_ok;
    logic [31:0]        enc_bits;

    always_comb begin
        enc_e    = $signed({ra.exp[15], ra.exp}) + fpsu_pkg::EXP_BIAS;
        enc_ok   = 1'b1;
        enc_bits = {ra.neg, 31'd0};
        if (ra.kind == fpsu_pkg::K_INF) begin
            enc_bits = {ra.neg, 31'd0} | fpsu_pkg::INF_BITS;
        end else if (ra.kind != fpsu_pkg::K_ZERO) begin
            enc_ok   = (enc_e > 17'sd0) && (enc_e < fpsu_pkg::EXP_MAX) && ra.sig[23];
            enc_bits = {ra.neg, enc_e[7:0], ra.sig[22:0]};
        end
    end

    // aligned signed sum
    logic [31:0]        va, vb;
    logic signed [33:0] sa, sb, sum;

    always_comb begin
        va  = r_sha[5] ? 32'd0 : ({r_asig, 8'd0} >> r_sha[4:0]);
        vb  = r_shb[5] ? 32'd0 : ({r_bsig, 8'd0} >> r_shb[4:0]);
        sa  = r_aneg ? -$signed({2'b00, va}) : $signed({2'b00, va});
        sb  = r_bneg ? -$signed({2'b00, vb}) : $signed({2'b00, vb});
        sum = sa + sb;
    end

    // one restoring divide step
    logic [24:0] dv_t, dv_d;
    logic        dv_ge;

    assign dv_t  = {r_rem, r_feed};
    assign dv_d  = {1'b0, r_dvsr};
    assign dv_ge = dv_t >= dv_d;

    assign o_sts.path      = sp_path;
    assign o_sts.add_zero  = (sum == 34'sd0);
    assign o_sts.norm_done = (r_mag[32:31] == 2'b01);
    assign o_sts.div_last  = (r_cnt == fpsu_pkg::CNT_W'(fpsu_pkg::DIV_STEPS - 1));

    // next-state logic
    logic [7:0]  ld_e;
    logic [22:0] ld_f;
    logic        fault, ze_hit, pend_ldcw;
    logic [5:0]  new_mask;
    logic        carry;

    always_comb begin
        n_req = r_req;   n_word = r_word;   n_idx = r_idx;
        n_top = r_top;   n_occ = r_occ;
        n_ie = r_ie;     n_ze = r_ze;       n_sf = r_sf;     n_es = r_es;
        n_mask = r_mask; n_pend = r_pend;
        n_code = r_code; n_store = r_store; n_wr = r_wr;     n_wslot = r_wslot;
        n_res = r_res;   n_neg = r_neg;     n_exp = r_exp;
        n_asig = r_asig; n_bsig = r_bsig;   n_aneg = r_aneg; n_bneg = r_bneg;
        n_sha = r_sha;   n_shb = r_shb;     n_mag = r_mag;   n_prod = r_prod;
        n_rem = r_rem;   n_dvsr = r_dvsr;   n_feed = r_feed; n_q = r_q;
        n_cnt = r_cnt;
        ld_e      = r_word[30:23];
        ld_f      = r_word[22:0];
        fault     = 1'b0;
        ze_hit    = 1'b0;
        new_mask  = r_word[5:0];
        pend_ldcw = (r_ie && !new_mask[0]) || (r_ze && !new_mask[2]);
        carry     = r_prod[47];

        // latch the instruction word
        if (i_cmd.accept) begin
            n_req  = fpsu_pkg::t_req'(i_req_type);
            n_word = i_operand_bits;
            n_idx  = i_st_index;
        end

        // execute with both operands read
        if (i_cmd.exec) begin
            n_code  = 1'b0;
            n_store = 32'd0;
            n_wr    = 1'b0;
            n_wslot = r_top;
            unique case (r_req)
                fpsu_pkg::R_INIT: begin
                    n_top  = '0;
                    n_occ  = '0;
                    n_ie   = 1'b0; n_ze = 1'b0; n_sf = 1'b0; n_es = 1'b0;
                    n_mask = fpsu_pkg::CTRL_DEFAULT[5:0];
                    n_pend = 1'b0;
                end
                fpsu_pkg::R_LOAD: begin
                    if (ld_e == 8'hff || (ld_e == 8'd0 && ld_f != 23'd0)) begin
                        n_code = 1'b1;
                    end else if (r_occ[push_slot]) begin
                        fault = 1'b1;
                    end else begin
                        n_top            = push_slot;
                        n_occ[push_slot] = 1'b1;
                        n_wr             = 1'b1;
                        n_wslot          = push_slot;
                        if (ld_e == 8'd0) begin
                            n_res = '{kind: fpsu_pkg::K_ZERO, neg: r_word[31],
                                      exp: '0, sig: '0};
                        end else begin
                            n_res = '{kind: fpsu_pkg::K_FIN, neg: r_word[31],
                                      exp: 16'({8'd0, ld_e} - 16'd127),
                                      sig: {1'b1, ld_f}};
                        end
                    end
                end
                fpsu_pkg::R_STORE: begin
                    if (!r_occ[r_top]) begin
                        fault = 1'b1;
                    end else if (!enc_ok) begin
                        n_code = 1'b1;
                    end else begin
                        n_store      = enc_bits;
                        n_occ[r_top] = 1'b0;
                        n_top        = r_top + PW'(1);
                    end
                end
                fpsu_pkg::R_LDCW: begin
                    n_mask = new_mask;
                    if (r_es && pend_ldcw) n_pend = 1'b1;
                end
                default: begin
                    if (!occ_ok) begin
                        fault = 1'b1;
                    end else if (sp_fail) begin
                        n_code = 1'b1;
                    end else begin
                        n_wr   = 1'b1;
                        n_res  = sp_res;
                        ze_hit = sp_ze;
                        n_neg  = ra.neg ^ rbx.neg;
                        unique case (sp_path)
                            fpsu_pkg::P_ADD: begin
                                n_exp  = a_lt_b ? rbx.exp : ra.exp;
                                n_sha  = !a_lt_b ? 6'd0 :
                                         (ndiff > 17'd31) ? 6'd32 : ndiff[5:0];
                                n_shb  = a_lt_b ? 6'd0 :
                                         (ediff > 17'sd31) ? 6'd32 : ediff[5:0];
                                n_asig = ra.sig;  n_bsig = rbx.sig;
                                n_aneg = ra.neg;  n_bneg = rbx.neg;
                            end
                            fpsu_pkg::P_MUL: begin
                                n_prod = ra.sig * rbx.sig;
                                n_exp  = ra.exp + rbx.exp;
                            end
                            fpsu_pkg::P_DIV: begin
                                n_rem  = {1'b0, ra.sig[23:1]};
                                n_feed = ra.sig[0];
                                n_dvsr = rbx.sig;
                                n_q    = '0;
                                n_cnt  = '0;
                                n_exp  = ra.exp - rbx.exp - 16'd1;
                            end
                            default: n_exp = r_exp;
                        endcase
                    end
                end
            endcase
            // raise exceptions, ES and pending when unmasked
            if (fault) begin
                n_ie = 1'b1;
                n_sf = 1'b1;
                if (!r_mask[0]) begin
                    n_es   = 1'b1;
                    n_pend = 1'b1;
                end
            end
            if (ze_hit) begin
                n_ze = 1'b1;
                if (!r_mask[2]) begin
                    n_es   = 1'b1;
                    n_pend = 1'b1;
                end
            end
        end

        // add the aligned significands
        if (i_cmd.add) begin
            if (sum == 34'sd0) begin
                n_res = '{kind: fpsu_pkg::K_ZERO, neg: 1'b0, exp: '0, sig: '0};
            end else begin
                n_neg = sum[33];
                n_mag = sum[33] ? 33'(-sum) : sum[32:0];
            end
        end

        // normalize one bit per cycle
        if (i_cmd.norm) begin
            if (r_mag[32:31] == 2'b01) begin
                n_res = '{kind: fpsu_pkg::K_FIN, neg: r_neg, exp: r_exp, sig: r_mag[31:8]};
            end else if (r_mag[32]) begin
                n_mag = r_mag >> 1;
                n_exp = r_exp + 16'd1;
            end else begin
                n_mag = r_mag << 1;
                n_exp = r_exp - 16'd1;
            end
        end

        // one quotient bit per cycle
        if (i_cmd.div) begin
            n_rem  = dv_ge ? 24'(dv_t - dv_d) : dv_t[23:0];
            n_q    = {r_q[23:0], dv_ge};
            n_feed = 1'b0;
            n_cnt  = r_cnt + fpsu_pkg::CNT_W'(1);
        end

        // pack product or quotient
        if (i_cmd.pack) begin
            if (r_req == fpsu_pkg::R_MUL) begin
                n_res = '{kind: fpsu_pkg::K_FIN, neg: r_neg,
                          exp: r_exp + {15'd0, carry},
                          sig: carry ? r_prod[47:24] : r_prod[46:23]};
            end else begin
                n_res = '{kind: fpsu_pkg::K_FIN, neg: r_neg,
                          exp: r_exp + {15'd0, r_q[24]},
                          sig: r_q[24] ? r_q[24:1] : r_q[23:0]};
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_occ  <= '0;
            r_ie   <= 1'b0;
            r_ze   <= 1'b0;
            r_sf   <= 1'b0;
            r_es   <= 1'b0;
            r_mask <= fpsu_pkg::CTRL_DEFAULT[5:0];
            r_pend <= 1'b0;
            r_code <= 1'b0;
            r_wr   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_top  <= n_top;
            r_occ  <= n_occ;
            r_ie   <= n_ie;
            r_ze   <= n_ze;
            r_sf   <= n_sf;
            r_es   <= n_es;
            r_mask <= n_mask;
            r_pend <= n_pend;
            r_code <= n_code;
            r_wr   <= n_wr;
            r_cnt  <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_word  <= n_word;
        r_idx   <= n_idx;
        r_store <= n_store;
        r_wslot <= n_wslot;
        r_res   <= n_res;
        r_neg   <= n_neg;
        r_exp   <= n_exp;
        r_asig  <= n_asig;
        r_bsig  <= n_bsig;
        r_aneg  <= n_aneg;
        r_bneg  <= n_bneg;
        r_sha   <= n_sha;
        r_shb   <= n_shb;
        r_mag   <= n_mag;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_dvsr  <= n_dvsr;
        r_feed  <= n_feed;
        r_q     <= n_q;
    end

    assign o_result_code       = r_code;
    assign o_store_bits        = r_store;
    assign o_status_out        = {2'b00, r_top, 3'b000, r_es, r_sf, 3'b000, r_ze, 1'b0, r_ie};
    assign o_control_out       = (fpsu_pkg::CTRL_DEFAULT & ~fpsu_pkg::CTRL_EXC_MASK) |
                                 {10'd0, r_mask};
    assign o_tag_valid_bits    = r_occ;
    assign o_exception_pending = r_pend;

    `FPSU_ASSERT_NEXT(a_norm_hidden, i_cmd.norm && o_sts.norm_done, r_res.sig[23],
        "normalized sum lost hidden bit")
    `FPSU_ASSERT_NOW(a_write_occupied, i_cmd.fin && r_wr, r_occ[r_wslot],
        "write to empty register")

endmodule

// File: rtl/fpu_stack_execution_unit.sv
// channel | valid   | stall   | fields
// --------+---------+---------+--------------------------------------------------
// in      | i_valid | o_stall | i_req_type, i_operand_bits, i_st_index
// out     | o_valid | i_stall | o_result_code, o_store_bits, o_status_out,
//         |         |         | o_control_out, o_tag_valid_bits, o_exception_pending
//
// One instruction at a time. Init, load, store, load control and arithmetic
// with a zero or infinity operand pass through read, execute, finish and output.
// Multiply adds a pack step; divide adds the 25-step restoring divider and pack;
// add and subtract add a sum step and then normalize one bit per step,
// but skip normalizing when the sum is exactly zero.
// Reset (synchronous, active low) empties the stack; stack values need no clear.
// A stalled result word holds, and no new word is taken until it is delivered.
module fpu_stack_execution_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_operand_bits,
    input  logic [2:0]  i_st_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_code,
    output logic [31:0] o_store_bits,
    output logic [15:0] o_status_out,
    output logic [15:0] o_control_out,
    output logic [7:0]  o_tag_valid_bits,
    output logic        o_exception_pending
);

    fpsu_pkg::t_cmd cmd;
    fpsu_pkg::t_sts sts;

    fpsu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    fpsu_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_req_type          (i_req_type),
        .i_operand_bits      (i_operand_bits),
        .i_st_index          (i_st_index),
        .o_result_code       (o_result_code),
        .o_store_bits        (o_store_bits),
        .o_status_out        (o_status_out),
        .o_control_out       (o_control_out),
        .o_tag_valid_bits    (o_tag_valid_bits),
        .o_exception_pending (o_exception_pending)
    );

endmodule

// File: tb/tb_fpu_stack_execution_unit.sv
module tb_fpu_stack_execution_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import fpsu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_WORDS   = 1530;
    localparam logic [15:0] SW_IE  = 16'h0001;
    localparam logic [15:0] SW_ZE  = 16'h0004;
    localparam logic [15:0] SW_SF  = 16'h0040;
    localparam logic [15:0] SW_ES  = 16'h0080;
    localparam logic [15:0] SW_TOP = 16'h3800;

    typedef struct packed {
        logic        code;
        logic [31:0] store;
        logic [15:0] status;
        logic [15:0] control;
        logic [7:0]  tags;
        logic        pending;
    } t_reply;

    typedef struct {
        t_req        req;
        logic [31:0] operand;
        logic [2:0]  idx;
        logic        typed;
        t_reply      reply;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_req_type;
    logic [31:0] i_operand_bits;
    logic [2:0]  i_st_index;
    logic        o_valid;
    logic        i_stall;
    logic        o_result_code;
    logic [31:0] o_store_bits;
    logic [15:0] o_status_out;
    logic [15:0] o_control_out;
    logic [7:0]  o_tag_valid_bits;
    logic        o_exception_pending;

    fpu_stack_execution_unit DUT (.*);

    // Shadow copy of the register stack
    t_fval       regs [STACK_DEPTH];
    logic        occupied [STACK_DEPTH];
    logic [2:0]  top;
    logic [15:0] sw_shadow;
    logic [15:0] cw_shadow;
    logic        pending;

    t_reply      expected_replies [$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_receiver;
    bit          stimulus_done;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_fval zero_val(logic neg);
        t_fval z;
        z.kind = K_ZERO;
        z.neg  = neg;
        z.exp  = '0;
        z.sig  = '0;
        return z;
    endfunction

    function automatic int signed exp_int(logic [15:0] e);
        return int'($signed(e));
    endfunction

    function automatic void clear_stack();
        for (int i = 0; i < STACK_DEPTH; i++) begin
            regs[i]     = zero_val(1'b0);
            occupied[i] = 1'b0;
        end
        top       = '0;
        sw_shadow = '0;
        cw_shadow = CTRL_DEFAULT;
        pending   = 1'b0;
    endfunction

    function automatic void signal_exc(logic [15:0] bits, logic [15:0] mask);
        sw_shadow |= bits;
        if ((cw_shadow & mask) != mask) begin
            sw_shadow |= SW_ES;
            pending = 1'b1;
        end
    endfunction

    function automatic bit fp_add(t_fval a, t_fval b, output t_fval r);
        int signed   ea, eb, e;
        longint      va, vb, s;
        longint unsigned m;
        if (a.kind == K_ZERO) begin
            r = b;
            return 1;
        end
        if (b.kind == K_ZERO) begin
            r = a;
            return 1;
        end
        if (a.kind != K_FIN || b.kind != K_FIN) return 0;
        ea = exp_int(a.exp);
        eb = exp_int(b.exp);
        e  = (ea >= eb) ? ea : eb;
        va = (e - ea >= 32) ? 0 : longint'((64'(a.sig) << 8) >> (e - ea));
        vb = (e - eb >= 32) ? 0 : longint'((64'(b.sig) << 8) >> (e - eb));
        if (a.neg) va = -va;
        if (b.neg) vb = -vb;
        s = va + vb;
        if (s == 0) begin
            r = zero_val(1'b0);
            return 1;
        end
        r.neg = s < 0;
        m = (s < 0) ? -s : s;
        while (m >= 64'h1_0000_0000) begin
            m >>= 1;
            e++;
        end
        while (m < 64'h8000_0000) begin
            m <<= 1;
            e--;
        end
        r.kind = K_FIN;
        r.exp  = e[15:0];
        r.sig  = m[31:8];
        return 1;
    endfunction

    function automatic bit fp_mul(t_fval a, t_fval b, output t_fval r);
        logic [47:0] p;
        int signed   e;
        if (a.kind == K_ZERO || b.kind == K_ZERO) begin
            r = zero_val(a.neg ^ b.neg);
            return 1;
        end
        if (a.kind != K_FIN || b.kind != K_FIN) return 0;
        p = 48'(a.sig) * 48'(b.sig);
        e = exp_int(a.exp) + exp_int(b.exp) + int'(p[47]);
        r.kind = K_FIN;
        r.neg  = a.neg ^ b.neg;
        r.exp  = e[15:0];
        r.sig  = p[47] ? p[47:24] : p[46:23];
        return 1;
    endfunction

    // Divide-by-zero raises its flag here, so this one works on the shadow state
    function automatic bit fp_div(t_fval a, t_fval b, output t_fval r);
        logic [63:0] q;
        int signed   e;
        if (b.kind == K_ZERO) begin
            signal_exc(SW_ZE, SW_ZE);
            r = zero_val(a.neg ^ b.neg);
            r.kind = K_INF;
            return 1;
        end
        if (a.kind == K_ZERO) begin
            r = zero_val(a.neg ^ b.neg);
            return 1;
        end
        if (a.kind != K_FIN || b.kind != K_FIN) return 0;
        if (b.sig == 0) return 0;
        q = (64'(a.sig) << 24) / 64'(b.sig);
        e = exp_int(a.exp) - exp_int(b.exp) - 1;
        if (q >= 64'h100_0000) begin
            q >>= 1;
            e++;
        end
        r.kind = K_FIN;
        r.neg  = a.neg ^ b.neg;
        r.exp  = e[15:0];
        r.sig  = q[23:0];
        return 1;
    endfunction

    function automatic bit pack_single(t_fval v, output logic [31:0] bits);
        int signed e;
        bits = {v.neg, 31'd0};
        if (v.kind == K_ZERO) return 1;
        if (v.kind == K_INF) begin
            bits |= INF_BITS;
            return 1;
        end
        e = exp_int(v.exp) + 127;
        if (e <= 0 || e >= 255 || !v.sig[23]) return 0;
        bits |= {1'b0, e[7:0], v.sig[22:0]};
        return 1;
    endfunction

    // Execute one instruction on the shadow stack and return its reply
    function automatic t_reply execute_instr(t_req req, logic [31:0] w, logic [2:0] idx);
        t_reply      rep;
        logic [2:0]  d, s;
        logic [7:0]  be;
        logic [15:0] exc;
        t_fval       a, b, r, v;
        bit          ok;
        rep = '0;
        case (req)
            R_INIT: begin
                clear_stack();
            end
            R_LOAD: begin
                be = w[30:23];
                if (be == 8'hff || (be == 0 && w[22:0] != 0)) begin
                    rep.code = 1'b1;
                end else begin
                    d = top - 3'd1;
                    v = zero_val(w[31]);
                    if (be != 0) begin
                        v.kind = K_FIN;
                        v.exp  = 16'(int'(be) - 127);
                        v.sig  = {1'b1, w[22:0]};
                    end
                    if (occupied[d]) begin
                        signal_exc(SW_IE | SW_SF, SW_IE);
                    end else begin
                        top = d;
                        regs[d] = v;
                        occupied[d] = 1'b1;
                    end
                end
            end
            R_STORE: begin
                if (!occupied[top]) begin
                    signal_exc(SW_IE | SW_SF, SW_IE);
                end else if (!pack_single(regs[top], rep.store)) begin
                    rep.store = '0;
                    rep.code  = 1'b1;
                end else begin
                    occupied[top] = 1'b0;
                    top = top + 3'd1;
                end
            end
            R_LDCW: begin
                cw_shadow = (w[15:0] & CTRL_EXC_MASK) | (CTRL_DEFAULT & ~CTRL_EXC_MASK);
                exc = sw_shadow & CTRL_EXC_MASK;
                if ((sw_shadow & SW_ES) != 0 && (cw_shadow & exc) != exc) pending = 1'b1;
            end
            default: begin
                d = top;
                s = top + idx;
                if (!occupied[d] || !occupied[s]) begin
                    signal_exc(SW_IE | SW_SF, SW_IE);
                end else begin
                    a = regs[d];
                    b = regs[s];
                    case (req)
                        R_ADD: ok = fp_add(a, b, r);
                        R_SUB: begin
                            b.neg = ~b.neg;
                            ok = fp_add(a, b, r);
                        end
                        R_MUL: ok = fp_mul(a, b, r);
                        default: ok = fp_div(a, b, r);
                    endcase
                    if (ok) regs[d] = r;
                    else rep.code = 1'b1;
                end
            end
        endcase
        sw_shadow   = (sw_shadow & ~SW_TOP) | (16'(top) << 11);
        rep.status  = sw_shadow;
        rep.control = cw_shadow;
        for (int i = 0; i < STACK_DEPTH; i++) rep.tags[i] = occupied[i];
        rep.pending = pending;
        return rep;
    endfunction

    // Drive one instruction and wait for its acceptance
    task automatic send_instr(t_req req, logic [31:0] w, logic [2:0] idx,
                              bit typed, t_reply typed_reply);
        t_reply rep;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_operand_bits <= w;
        i_st_index     <= idx;
        do @(posedge i_clk); while (o_stall);
        rep = execute_instr(req, w, idx);
        if (typed && rep != typed_reply)
            $error("table row disagrees with prediction for req %0d", req);
        expected_replies.push_back(typed ? typed_reply : rep);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    // Random single: mostly normal values, sometimes zero, specials, denormals
    function automatic logic [31:0] rand_single();
        logic [31:0] w;
        int          pick;
        w    = $urandom();
        pick = $urandom_range(99);
        if (pick < 70) w[30:23] = 8'($urandom_range(100, 154));
        else if (pick < 80) w[30:0] = '0;
        else if (pick < 85) w[30:23] = 8'hff;
        else if (pick < 90) w[30:23] = 8'h00;
        return w;
    endfunction

    function automatic t_reply rpl(logic code, logic [31:0] st, logic [15:0] sw,
                                   logic [15:0] cw, logic [7:0] tg, logic pd);
        t_reply r;
        r = {code, st, sw, cw, tg, pd};
        return r;
    endfunction

    t_row directed [$];

    task automatic add_row(t_req req, logic [31:0] w, logic [2:0] idx,
                           bit typed = 0, t_reply rep = '0);
        t_row r;
        r.req = req;
        r.operand = w;
        r.idx = idx;
        r.typed = typed;
        r.reply = rep;
        directed.push_back(r);
    endtask

    task automatic build_table();
        // Empty stack faults after reset: masked, so no ES
        add_row(R_STORE, 32'h0, 3'd0, 1, rpl(0, 0, SW_IE | SW_SF, CTRL_DEFAULT, 8'h00, 0));
        add_row(R_ADD, 32'h0, 3'd0, 1, rpl(0, 0, SW_IE | SW_SF, CTRL_DEFAULT, 8'h00, 0));
        add_row(R_INIT, 32'hffff_ffff, 3'd7, 1, rpl(0, 0, 16'h0, CTRL_DEFAULT, 8'h00, 0));
        // Unsupported loads change nothing
        add_row(R_LOAD, 32'h7f80_0000, 3'd0, 1, rpl(1, 0, 16'h0, CTRL_DEFAULT, 8'h00, 0));
        add_row(R_LOAD, 32'hffc0_0001, 3'd0, 1, rpl(1, 0, 16'h0, CTRL_DEFAULT, 8'h00, 0));
        add_row(R_LOAD, 32'h0000_0001, 3'd0, 1, rpl(1, 0, 16'h0, CTRL_DEFAULT, 8'h00, 0));
        add_row(R_LOAD, 32'h7f7f_ffff, 3'd0, 1, rpl(0, 0, 16'h3800, CTRL_DEFAULT, 8'h80, 0));
        add_row(R_LOAD, 32'h8080_0000, 3'd0);
        add_row(R_LOAD, 32'h8000_0000, 3'd0);
        add_row(R_LOAD, 32'h4000_0000, 3'd0);
        add_row(R_ADD, 32'h0, 3'd2);
        add_row(R_SUB, 32'h0, 3'd1);
        add_row(R_MUL, 32'h0, 3'd3);
        add_row(R_DIV, 32'h0, 3'd2);
        add_row(R_DIV, 32'h0, 3'd1);
        add_row(R_ADD, 32'h0, 3'd1);
        add_row(R_STORE, 32'h0, 3'd0);
        add_row(R_MUL, 32'h0, 3'd2);
        add_row(R_MUL, 32'h0, 3'd0);
        add_row(R_STORE, 32'h0, 3'd0);
        add_row(R_LDCW, 32'hffff_ffc0, 3'd0);
        add_row(R_STORE, 32'h0, 3'd0);
        add_row(R_STORE, 32'h0, 3'd0);
        add_row(R_LDCW, 32'h0000_ffff, 3'd0);
        add_row(R_INIT, 32'h0, 3'd0);
    endtask

    // Random stream: loads to fill, arithmetic, stores, occasional control or init
    task automatic random_instr();
        int   pick;
        t_req req;
        pick = $urandom_range(99);
        if (pick < 2) req = R_INIT;
        else if (pick < 6) req = R_LDCW;
        else if (pick < 30) req = R_LOAD;
        else if (pick < 50) req = R_STORE;
        else req = t_req'($urandom_range(4, 7));
        send_instr(req, (req == R_LOAD) ? rand_single() : $urandom(),
                   3'($urandom_range(7)), 0, '0);
    endtask

    // Sink side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_receiver || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each delivered word with the oldest expectation
    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                exp_r = expected_replies.pop_front();
                if (o_result_code !== exp_r.code) begin
                    $error("result_code exp %0h got %0h", exp_r.code, o_result_code);
                    errors++;
                end
                if (o_store_bits !== exp_r.store) begin
                    $error("store_bits exp %h got %h", exp_r.store, o_store_bits);
                    errors++;
                end
                if (o_status_out !== exp_r.status) begin
                    $error("status_out exp %h got %h", exp_r.status, o_status_out);
                    errors++;
                end
                if (o_control_out !== exp_r.control) begin
                    $error("control_out exp %h got %h", exp_r.control, o_control_out);
                    errors++;
                end
                if (o_tag_valid_bits !== exp_r.tags) begin
                    $error("tag_valid_bits exp %h got %h", exp_r.tags, o_tag_valid_bits);
                    errors++;
                end
                if (o_exception_pending !== exp_r.pending) begin
                    $error("exception_pending exp %0h got %0h", exp_r.pending,
                           o_exception_pending);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || stimulus_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        hold_receiver = 1'b0;
        stimulus_done = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = '0;
        i_operand_bits = '0;
        i_st_index = '0;
        clear_stack();
        sw_shadow = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_table();
        foreach (directed[k])
            send_instr(directed[k].req, directed[k].operand, directed[k].idx,
                       directed[k].typed, directed[k].reply);
        drain();

        // Hold the sink while the source keeps offering, so the block backs up
        fork
            begin
                hold_receiver <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_receiver <= 1'b0;
            end
            begin
                for (int k = 0; k < 10; k++) random_instr();
            end
        join
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 77 : 0;
            recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 17 : 0;
            for (int k = 0; k < RANDOM_WORDS / 3; k++) begin
                random_instr();
            end
            drain();
        end

        stimulus_done = 1'b1;
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
